### rtl/nested_loop_equi_join_macros.svh
// Assertion macros for the join engine, used by the scan sequencer.
`ifndef NESTED_LOOP_EQUI_JOIN_MACROS_SVH
`define NESTED_LOOP_EQUI_JOIN_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define NLJ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define NLJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/nlj_pkg.sv
// Shared types, codes and defaults of the nested-loop equi-join engine.
`timescale 1ns / 1ps

package nlj_pkg;

  // Column and output geometry.
  localparam int COL_W      = 32;
  localparam int MAX_COLS   = 4;
  localparam int NUM_OUT    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  // Defaults for the top-level parameters.
  localparam int DEF_B_ROWS   = 64;
  localparam int DEF_COLS     = 4;
  localparam int DEF_OUT_COLS = 4;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COL_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COL_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS_USED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SRC0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SRC1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SRC2      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SRC3      = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [2:0] RST_OUT_COLS_USED = 3'd4;
  localparam logic [2:0] RST_OUT_SRC0      = 3'd0;
  localparam logic [2:0] RST_OUT_SRC1      = 3'd1;
  localparam logic [2:0] RST_OUT_SRC2      = 3'd4;
  localparam logic [2:0] RST_OUT_SRC3      = 3'd5;

  // Configuration seen by the scan sequencer.
  typedef struct packed {
    logic [1:0]           key_col_a;
    logic [1:0]           key_col_b;
    logic [2:0]           out_cols_used;
    logic [NUM_OUT-1:0][2:0] out_src;
  } cfg_t;

endpackage

### rtl/nlj_if.sv
// Handshake interfaces for the row input channel and the joined-row output channel.
`timescale 1ns / 1ps

interface nlj_row_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] col_value0;
  logic signed [31:0] col_value1;
  logic signed [31:0] col_value2;
  logic signed [31:0] col_value3;

  modport source (output valid, operation, col_value0, col_value1, col_value2, col_value3,
                  input ready);
  modport sink   (input valid, operation, col_value0, col_value1, col_value2, col_value3,
                  output ready);
endinterface

interface nlj_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_value0;
  logic signed [31:0] out_value1;
  logic signed [31:0] out_value2;
  logic signed [31:0] out_value3;
  logic              last_match;

  modport source (output valid, out_value0, out_value1, out_value2, out_value3, last_match,
                  input ready);
  modport sink   (input valid, out_value0, out_value1, out_value2, out_value3, last_match,
                  output ready);
endinterface

### rtl/nlj_row_store.sv
// Row store memory: one write port and one registered read port with enable.
`timescale 1ns / 1ps

module nlj_row_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write and registered read; the read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nlj_scan.sv
// Scan sequencer: loads and clears the store, walks it for each probe and emits joined rows.
`timescale 1ns / 1ps
`include "nested_loop_equi_join_macros.svh"

module nlj_scan import nlj_pkg::*; #(
  parameter int B_ROWS   = DEF_B_ROWS,
  parameter int COLS     = DEF_COLS,
  parameter int OUT_COLS = DEF_OUT_COLS
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  nlj_row_if.sink   row_in,
  nlj_res_if.source res_out
);

  localparam int AW = (B_ROWS > 1) ? $clog2(B_ROWS) : 1;
  localparam int CW = $clog2(B_ROWS + 1);
  localparam int RW = COLS * COL_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(B_ROWS);
  localparam logic [2:0]    OUT_MAX   = 3'(OUT_COLS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] issue;
  logic          data_valid;
  logic [COLS-1:0][COL_W-1:0] a_row;
  logic          held_valid;
  logic [NUM_OUT-1:0][COL_W-1:0] held_val;
  logic          out_valid;
  logic          out_last;
  logic [NUM_OUT-1:0][COL_W-1:0] out_val;

  logic [MAX_COLS-1:0][COL_W-1:0] in_full;
  logic [MAX_COLS-1:0][COL_W-1:0] a_full;
  logic [MAX_COLS-1:0][COL_W-1:0] b_full;
  logic [COLS-1:0][COL_W-1:0]     in_row;
  logic [RW-1:0]                  rdata;
  logic [NUM_OUT-1:0][COL_W-1:0]  proj;
  logic [2:0]    used;
  logic          in_fire, out_free, match, can_take, consume, advance, issue_ok;
  logic          push_mid, push_last, we, room;

  // Input columns as an array; only the first COLS columns are kept.
  assign in_full[0] = row_in.col_value0;
  assign in_full[1] = row_in.col_value1;
  assign in_full[2] = row_in.col_value2;
  assign in_full[3] = row_in.col_value3;

  // Columns beyond COLS read as zero on both tables.
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_pad
    if (c < COLS) begin : g_col
      assign in_row[c] = in_full[c];
      assign a_full[c] = a_row[c];
      assign b_full[c] = rdata[c*COL_W +: COL_W];
    end else begin : g_zero
      assign a_full[c] = '0;
      assign b_full[c] = '0;
    end
  end

  nlj_row_store #(
    .DEPTH (B_ROWS),
    .AW    (AW),
    .W     (RW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (in_row),
    .re    (issue_ok),
    .raddr (issue[AW-1:0]),
    .rdata (rdata)
  );

  // Key compare and output projection of the row now at the read port.
  assign match = (a_full[cfg.key_col_a] == b_full[cfg.key_col_b]);
  assign used  = (cfg.out_cols_used > OUT_MAX) ? OUT_MAX : cfg.out_cols_used;

  always_comb begin
    for (int j = 0; j < NUM_OUT; j++) begin
      if (3'(j) < used) begin
        proj[j] = cfg.out_src[j][2] ? b_full[cfg.out_src[j][1:0]]
                                    : a_full[cfg.out_src[j][1:0]];
      end else begin
        proj[j] = '0;
      end
    end
  end

  // Handshake and scan control.
  assign row_in.ready = (state == ST_IDLE);
  assign in_fire  = row_in.valid && row_in.ready;
  assign out_free = !out_valid || res_out.ready;
  assign room     = (count < COUNT_MAX);
  assign we       = in_fire && (row_in.operation == OP_LOAD) && room;
  assign can_take = !match || !held_valid || out_free;
  assign consume  = (state == ST_SCAN) && data_valid && can_take;
  assign advance  = (state == ST_SCAN) && (!data_valid || can_take);
  assign issue_ok = advance && (issue < count);
  assign push_mid  = consume && match && held_valid;
  assign push_last = (state == ST_FLUSH) && held_valid && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (row_in.operation == OP_PROBE) && (count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!data_valid && (issue == count)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!held_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      issue      <= '0;
      data_valid <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        count <= count + CW'(1);
      end else if (in_fire && (row_in.operation == OP_CLEAR)) begin
        count <= '0;
      end
      if (in_fire) begin
        issue <= '0;
      end else if (issue_ok) begin
        issue <= issue + CW'(1);
      end
      if (advance) begin
        data_valid <= issue_ok;
      end
      if (consume && match) begin
        held_valid <= 1'b1;
      end else if (push_last) begin
        held_valid <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: probe row, pending match and output item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_row <= in_row;
    end
    if (consume && match) begin
      held_val <= proj;
    end
    if (push_mid || push_last) begin
      out_val  <= held_val;
      out_last <= push_last;
    end
  end

  assign res_out.valid      = out_valid;
  assign res_out.out_value0 = $signed(out_val[0]);
  assign res_out.out_value1 = $signed(out_val[1]);
  assign res_out.out_value2 = $signed(out_val[2]);
  assign res_out.out_value3 = $signed(out_val[3]);
  assign res_out.last_match = out_last;

  // Checks on the sequencer.
  `NLJ_ASSERT_IMPL(a_ready_idle, row_in.ready, !held_valid && !data_valid, "ready with a probe in flight")
  `NLJ_ASSERT_IMPL(a_count_bound, 1'b1, count <= COUNT_MAX, "row count beyond store depth")
  `NLJ_ASSERT_IMPL(a_store_quiet, we, state == ST_IDLE, "store written during a scan")
  `NLJ_ASSERT_NEXT(a_flush_done, push_last, (state == ST_IDLE) && out_valid && out_last, "last item not presented")

endmodule

### rtl/nested_loop_equi_join.sv
// Usage: the row_in channel takes load, probe and clear items; each item is accepted
// when valid and ready are both high. A load appends its row to the row store (ignored
// once the store is full), and a clear empties it. A probe walks the stored rows in
// load order through one compare unit, one row per cycle while the output does not
// stall, and ready stays low meanwhile, while the rows are read through the single
// read port of the row store, the last row is compared, and the scan drains and
// flushes. A probe on an empty store leaves ready high. Each match gives one joined
// item on res_out; the last of a probe carries last_match. A match is held until the
// next match or the end of the scan shows whether it is the last, so the first item
// waits for a second match, and a lone match for the end of the scan.
// An output register holds the finished item, so the next input item is accepted while
// it waits; when the receiver stalls, the scan holds its place until the pending match
// can move on. The configuration port writes one register per cycle with cfg_we; the user
// must use it only while the block is idle, which the block itself has no guard against.
// Reset empties the store, restores the register defaults and drops any held item.
`timescale 1ns / 1ps

module nested_loop_equi_join import nlj_pkg::*; #(
  parameter int B_ROWS   = DEF_B_ROWS,
  parameter int COLS     = DEF_COLS,
  parameter int OUT_COLS = DEF_OUT_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  nlj_row_if.sink               row_in,
  nlj_res_if.source             res_out
);

  cfg_t cfg;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_col_a     <= '0;
      cfg.key_col_b     <= '0;
      cfg.out_cols_used <= RST_OUT_COLS_USED;
      cfg.out_src[0]    <= RST_OUT_SRC0;
      cfg.out_src[1]    <= RST_OUT_SRC1;
      cfg.out_src[2]    <= RST_OUT_SRC2;
      cfg.out_src[3]    <= RST_OUT_SRC3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_COL_A:     cfg.key_col_a     <= cfg_data[1:0];
        REG_KEY_COL_B:     cfg.key_col_b     <= cfg_data[1:0];
        REG_OUT_COLS_USED: cfg.out_cols_used <= cfg_data;
        REG_OUT_SRC0:      cfg.out_src[0]    <= cfg_data;
        REG_OUT_SRC1:      cfg.out_src[1]    <= cfg_data;
        REG_OUT_SRC2:      cfg.out_src[2]    <= cfg_data;
        REG_OUT_SRC3:      cfg.out_src[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  nlj_scan #(
    .B_ROWS   (B_ROWS),
    .COLS     (COLS),
    .OUT_COLS (OUT_COLS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .row_in  (row_in),
    .res_out (res_out)
  );

endmodule

### dv/nested_loop_equi_join_test.sv
// Self-checking testbench for the nested-loop equi-join engine.
`timescale 1ns / 1ps

module nested_loop_equi_join_test;
  import nlj_pkg::*;

  localparam int B_ROWS   = DEF_B_ROWS;
  localparam int COLS     = DEF_COLS;
  localparam int OUT_COLS = DEF_OUT_COLS;

  // Codes the package leaves out: the spare operation and a register index past the list.
  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [31:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // A probe without matches may still be scanning after the last joined row has left.
  localparam int SCAN_SLACK     = B_ROWS + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0]                      operation;
    logic [MAX_COLS-1:0][COL_W-1:0] col;
  } row_item_t;

  typedef struct packed {
    logic [NUM_OUT-1:0][COL_W-1:0] value;
    logic                          last_match;
  } joined_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nlj_row_if row_if ();
  nlj_res_if res_if ();

  nested_loop_equi_join #(
    .B_ROWS   (B_ROWS),
    .COLS     (COLS),
    .OUT_COLS (OUT_COLS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_in    (row_if),
    .res_out   (res_if)
  );

  // Shadow copy of the row store, updated as items are accepted, and of the registers, as written.
  logic [MAX_COLS-1:0][COL_W-1:0] b_rows [B_ROWS];
  int                             b_count;
  cfg_t                           join_cfg;

  row_item_t   row_queue [$];
  joined_row_t joined_due [$];
  row_item_t   offered_row;

  int  rows_queued;
  int  rows_accepted;
  int  useful_rows;
  int  op_tally [4];
  int  rows_checked;
  int  mismatches;
  int  settings_applied;
  bit  calm;
  bit  drained_once;
  bit  await_results;
  int  send_gap;
  int  stall_left;
  int  quiet_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [COL_W-1:0] pick_col(logic [MAX_COLS-1:0][COL_W-1:0] r,
                                                logic [1:0] c);
    return (int'(c) < COLS) ? r[c] : '0;
  endfunction

  // Work out the joined rows that one accepted item causes, in store order.
  task automatic predict_join(row_item_t it);
    logic [COL_W-1:0] key;
    joined_row_t      held;
    bit               have_held;
    int               used;
    int               r;
    int               j;
    logic [2:0]       src;
    have_held = 1'b0;
    held = '0;
    case (it.operation)
      OP_LOAD: begin
        // Loads past capacity are dropped.
        if (b_count < B_ROWS) begin
          b_rows[b_count] = it.col;
          b_count++;
        end
      end
      OP_CLEAR: begin
        b_count = 0;
      end
      OP_PROBE: begin
        used = (int'(join_cfg.out_cols_used) > OUT_COLS) ? OUT_COLS
                                                         : int'(join_cfg.out_cols_used);
        key = pick_col(it.col, join_cfg.key_col_a);
        for (r = 0; r < b_count; r++) begin
          if (pick_col(b_rows[r], join_cfg.key_col_b) == key) begin
            if (have_held) joined_due = {joined_due, held};
            held = '0;
            for (j = 0; j < NUM_OUT; j++) begin
              if (j < used) begin
                src = join_cfg.out_src[j];
                held.value[j] = pick_col(src[2] ? b_rows[r] : it.col, src[1:0]);
              end
            end
            have_held = 1'b1;
          end
        end
        // Only the final match of the probe carries the end marker.
        if (have_held) begin
          held.last_match = 1'b1;
          joined_due = {joined_due, held};
        end
      end
      default: begin
        // The spare operation code is ignored.
      end
    endcase
  endtask

  task automatic flag_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compare one accepted joined item with the oldest prediction.
  task automatic check_joined_row();
    joined_row_t got;
    joined_row_t want;
    bit          bad;
    int          j;
    got.value[0]   = res_if.out_value0;
    got.value[1]   = res_if.out_value1;
    got.value[2]   = res_if.out_value2;
    got.value[3]   = res_if.out_value3;
    got.last_match = res_if.last_match;
    rows_checked++;
    if (joined_due.size() == 0) begin
      flag_mismatch($sformatf("joined row %h %h %h %h last %b with none predicted",
                              got.value[0], got.value[1], got.value[2], got.value[3],
                              got.last_match));
      return;
    end
    want = joined_due.pop_front();
    bad = (got.last_match !== want.last_match);
    for (j = 0; j < NUM_OUT; j++) begin
      if (got.value[j] !== want.value[j]) bad = 1'b1;
    end
    if (bad) begin
      flag_mismatch($sformatf("expected %h %h %h %h last %b, got %h %h %h %h last %b",
                              want.value[0], want.value[1], want.value[2], want.value[3],
                              want.last_match, got.value[0], got.value[1], got.value[2],
                              got.value[3], got.last_match));
    end
  endtask

  // Row driver: offers queued items, with random gaps and an occasional wait for results.
  always @(posedge clk) begin : drive_rows
    bit taken;
    if (rst) begin
      row_if.valid  <= 1'b0;
      send_gap      = 0;
      await_results = 1'b0;
    end else begin
      taken = row_if.valid && row_if.ready;
      if (taken) begin
        predict_join(offered_row);
        rows_accepted++;
        op_tally[offered_row.operation]++;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
        if (!calm && offered_row.operation == OP_PROBE &&
            (!drained_once || $urandom_range(0, 7) == 0)) begin
          await_results = 1'b1;
          drained_once  = 1'b1;
        end
      end
      if (row_if.valid && !taken) begin
        // Hold the item until the engine takes it.
      end else if (send_gap > 0) begin
        send_gap--;
        row_if.valid <= 1'b0;
      end else if (await_results && joined_due.size() != 0) begin
        row_if.valid <= 1'b0;
      end else if (row_queue.size() != 0) begin
        await_results = 1'b0;
        offered_row = row_queue.pop_front();
        row_if.operation  <= offered_row.operation;
        row_if.col_value0 <= offered_row.col[0];
        row_if.col_value1 <= offered_row.col[1];
        row_if.col_value2 <= offered_row.col[2];
        row_if.col_value3 <= offered_row.col[3];
        row_if.valid      <= 1'b1;
      end else begin
        await_results = 1'b0;
        row_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks accepted items and stalls the engine in random bursts.
  always @(posedge clk) begin : watch_results
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) check_joined_row();
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel nor the register port moves.
  always @(posedge clk) begin
    if (rst || cfg_we || (row_if.valid && row_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles, %0d joined rows still due",
                 WATCHDOG_LIMIT, joined_due.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic row_item_t row_of(logic [1:0] op, logic [31:0] c0, logic [31:0] c1,
                                       logic [31:0] c2, logic [31:0] c3);
    row_item_t it;
    it.operation = op;
    it.col[0] = c0;
    it.col[1] = c1;
    it.col[2] = c2;
    it.col[3] = c3;
    return it;
  endfunction

  // Random row with the given key placed in the key column.
  function automatic row_item_t keyed_row(logic [1:0] op, logic [1:0] key_col,
                                          logic [31:0] key);
    row_item_t it;
    it = row_of(op, $urandom, $urandom, $urandom, $urandom);
    it.col[key_col] = key;
    return it;
  endfunction

  task automatic push_row(row_item_t it);
    row_queue = {row_queue, it};
    rows_queued++;
    if (it.operation != OP_UNUSED) useful_rows++;
  endtask

  function automatic logic [31:0] extreme_or_random();
    case ($urandom_range(0, 3))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // One well-formed join: optional clear, a few loads, then probes on shared keys.
  task automatic queue_sequence(int max_loads);
    logic [31:0] pool [3];
    int          i;
    for (i = 0; i < 3; i++) pool[i] = extreme_or_random();
    if ($urandom_range(0, 3) != 0)
      push_row(row_of(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
    repeat ($urandom_range(0, max_loads))
      push_row(keyed_row(OP_LOAD, join_cfg.key_col_b, pool[$urandom_range(0, 2)]));
    repeat ($urandom_range(1, 4))
      push_row(keyed_row(OP_PROBE, join_cfg.key_col_a,
                         ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 2)]));
    // Some noise: a spare operation code or a probe on a random key.
    case ($urandom_range(0, 7))
      0:       push_row(row_of(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
      1:       push_row(row_of(OP_PROBE, $urandom, $urandom, $urandom, $urandom));
      default: ;
    endcase
  endtask

  task automatic queue_random_items(int target);
    int start;
    start = useful_rows;
    while (useful_rows - start < target) queue_sequence(6);
  endtask

  // Fill the store to capacity with one key, try two loads past it, then probe.
  task automatic queue_full_store();
    logic [31:0] fill_key;
    fill_key = $urandom;
    push_row(row_of(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
    repeat (B_ROWS) push_row(keyed_row(OP_LOAD, join_cfg.key_col_b, fill_key));
    repeat (2) push_row(keyed_row(OP_LOAD, join_cfg.key_col_b, ~fill_key));
    push_row(keyed_row(OP_PROBE, join_cfg.key_col_a, fill_key));
    push_row(keyed_row(OP_PROBE, join_cfg.key_col_a, ~fill_key));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_KEY_COL_A:     join_cfg.key_col_a     = data[1:0];
      REG_KEY_COL_B:     join_cfg.key_col_b     = data[1:0];
      REG_OUT_COLS_USED: join_cfg.out_cols_used = data;
      REG_OUT_SRC0:      join_cfg.out_src[0]    = data;
      REG_OUT_SRC1:      join_cfg.out_src[1]    = data;
      REG_OUT_SRC2:      join_cfg.out_src[2]    = data;
      REG_OUT_SRC3:      join_cfg.out_src[3]    = data;
      default:           ;
    endcase
  endtask

  // Write every register; the key registers get a random spare top bit.
  task automatic apply_settings(cfg_t s);
    write_reg(REG_KEY_COL_A, {1'($urandom_range(0, 1)), s.key_col_a});
    write_reg(REG_KEY_COL_B, {1'($urandom_range(0, 1)), s.key_col_b});
    write_reg(REG_OUT_COLS_USED, s.out_cols_used);
    write_reg(REG_OUT_SRC0, s.out_src[0]);
    write_reg(REG_OUT_SRC1, s.out_src[1]);
    write_reg(REG_OUT_SRC2, s.out_src[2]);
    write_reg(REG_OUT_SRC3, s.out_src[3]);
    write_reg(REG_UNUSED, 3'($urandom_range(0, 7)));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.key_col_a     = 2'($urandom_range(0, 3));
    s.key_col_b     = 2'($urandom_range(0, 3));
    s.out_cols_used = 3'($urandom_range(0, 7));
    for (int j = 0; j < NUM_OUT; j++) s.out_src[j] = 3'($urandom_range(0, 7));
    return s;
  endfunction

  function automatic cfg_t settings_of(logic [1:0] ka, logic [1:0] kb, logic [2:0] used,
                                       logic [2:0] s0, logic [2:0] s1, logic [2:0] s2,
                                       logic [2:0] s3);
    cfg_t s;
    s.key_col_a     = ka;
    s.key_col_b     = kb;
    s.out_cols_used = used;
    s.out_src[0]    = s0;
    s.out_src[1]    = s1;
    s.out_src[2]    = s2;
    s.out_src[3]    = s3;
    return s;
  endfunction

  // Wait until every item is taken and every joined row is back, then let a scan finish.
  task automatic settle();
    while (rows_accepted != rows_queued || joined_due.size() != 0) @(posedge clk);
    repeat (SCAN_SLACK) @(posedge clk);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_KEY_COL_A;
    cfg_data         = '0;
    row_if.valid     = 1'b0;
    row_if.operation = OP_LOAD;
    row_if.col_value0 = '0;
    row_if.col_value1 = '0;
    row_if.col_value2 = '0;
    row_if.col_value3 = '0;
    res_if.ready     = 1'b0;
    calm             = 1'b0;
    drained_once     = 1'b0;
    b_count          = 0;
    join_cfg         = settings_of(2'd0, 2'd0, RST_OUT_COLS_USED, RST_OUT_SRC0,
                                   RST_OUT_SRC1, RST_OUT_SRC2, RST_OUT_SRC3);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: the key sits in column 0.
    push_row(row_of(OP_PROBE, '0, KEY_MAX, ALL_ONES, KEY_MIN));
    push_row(row_of(OP_LOAD, KEY_MIN, KEY_MAX, ALL_ONES, '0));
    push_row(row_of(OP_LOAD, '0, KEY_MIN, KEY_MAX, ALL_ONES));
    push_row(row_of(OP_LOAD, KEY_MAX, '0, KEY_MIN, KEY_MAX));
    push_row(row_of(OP_LOAD, KEY_MIN, $urandom, $urandom, $urandom));
    push_row(row_of(OP_UNUSED, KEY_MIN, ALL_ONES, ALL_ONES, ALL_ONES));
    push_row(row_of(OP_PROBE, KEY_MIN, ALL_ONES, '0, KEY_MAX));
    push_row(row_of(OP_PROBE, KEY_MAX, $urandom, $urandom, $urandom));
    push_row(row_of(OP_PROBE, '0, KEY_MIN, KEY_MAX, '0));
    push_row(row_of(OP_PROBE, 32'd12345, $urandom, $urandom, $urandom));
    push_row(row_of(OP_PROBE, ALL_ONES, $urandom, $urandom, $urandom));
    push_row(row_of(OP_CLEAR, KEY_MIN, KEY_MAX, ALL_ONES, '0));
    push_row(row_of(OP_PROBE, KEY_MIN, $urandom, $urandom, $urandom));
    push_row(row_of(OP_LOAD, ALL_ONES, KEY_MIN, '0, KEY_MAX));
    push_row(row_of(OP_PROBE, ALL_ONES, ALL_ONES, KEY_MIN, '0));
    settle();

    // Zero output columns, keys on the last columns.
    apply_settings(settings_of(2'd3, 2'd2, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0));
    queue_random_items(5);
    settle();

    // Output count above the maximum, and a full store.
    apply_settings(settings_of(2'd1, 2'd1, 3'd7, 3'd7, 3'd6, 3'd2, 3'd3));
    queue_full_store();
    settle();

    apply_settings(random_settings());
    queue_random_items(5);
    settle();

    apply_settings(settings_of(2'd0, 2'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7));
    queue_random_items(5);
    settle();

    // Last part: no idling on either side.
    calm = 1'b1;
    apply_settings(random_settings());
    queue_random_items(5);
    settle();

    $display("Summary: %0d loads, %0d probes, %0d clears, %0d spare-code items",
             op_tally[OP_LOAD], op_tally[OP_PROBE], op_tally[OP_CLEAR], op_tally[OP_UNUSED]);
    $display("Summary: %0d joined rows checked over %0d register settings, %0d mismatches",
             rows_checked, settings_applied, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
